### src/observer_state_feedback_integrator_defines.svh
// Assertion macros for the observer state feedback integrator
`ifndef OBSERVER_STATE_FEEDBACK_INTEGRATOR_DEFINES_SVH
`define OBSERVER_STATE_FEEDBACK_INTEGRATOR_DEFINES_SVH

// same-cycle implication
`define OSFI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("osfi check failed");

// next-cycle implication
`define OSFI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("osfi check failed");

`endif

### src/osfi_pkg.sv
// Types, constants and helpers for the observer state feedback integrator
`default_nettype none
package osfi_pkg;

	typedef struct packed {
		logic [11:0]        setpoint_code;
		logic signed [15:0] encoder_count;
	} in_item_t;

	typedef struct packed {
		logic [11:0] position_code;
		logic [11:0] drive_code;
		logic        drive_clipped;
	} out_item_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef enum logic [2:0] {
		REG_GAIN_STATE1,
		REG_GAIN_STATE2,
		REG_GAIN_STATE3,
		REG_GAIN_INTEGRAL,
		REG_DRIVE_LIMIT,
		REG_ZERO_OFFSET,
		REG_DAC_GAIN
	} reg_idx_t;

	typedef enum logic [2:0] {
		TERM_EST1,
		TERM_EST2,
		TERM_EST3,
		TERM_KIX,
		TERM_POS
	} obs_term_t;

	typedef struct packed {
		logic signed [31:0] coef;
		obs_term_t          term;
		logic [1:0]         row;
	} obs_op_t;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	localparam logic [4:0] STEP_KIX   = 5'd0;
	localparam logic [4:0] STEP_FB1   = 5'd1;
	localparam logic [4:0] STEP_FB2   = 5'd2;
	localparam logic [4:0] STEP_FB3   = 5'd3;
	localparam logic [4:0] STEP_RIN   = 5'd4;
	localparam logic [4:0] STEP_POS   = 5'd5;
	localparam logic [4:0] STEP_PCODE = 5'd6;
	localparam logic [4:0] STEP_DCODE = 5'd7;
	localparam logic [4:0] STEP_OBS0  = 5'd8;
	localparam logic [4:0] STEP_OBS14 = 5'd22;
	localparam logic [4:0] STEP_LAST  = 5'd24;

	localparam logic signed [31:0] RST_GAIN_STATE1   = 32'sd141079;
	localparam logic signed [31:0] RST_GAIN_STATE2   = 32'sd957;
	localparam logic signed [31:0] RST_GAIN_STATE3   = 32'sd0;
	localparam logic signed [31:0] RST_GAIN_INTEGRAL = 32'sd537;
	localparam logic [30:0]        RST_DRIVE_LIMIT   = 31'd786432;
	localparam logic signed [31:0] RST_ZERO_OFFSET   = 32'sd26214;
	localparam logic [30:0]        RST_DAC_GAIN      = 31'd11182080;

	// reciprocals: 2^40/4095, 2^41/700, 2^37/700, rounded up
	localparam logic [32:0] RECIP_4095     = 33'd268501009;
	localparam logic [32:0] RECIP_700_POS  = 33'd3141461794;
	localparam logic [32:0] RECIP_700_CODE = 33'd196341363;
	localparam logic signed [31:0] SETPOINT_OFFSET = 32'sd1966;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic obs_op_t obs_op(input logic [4:0] s);
		obs_op_t o;
		case (s)
			5'd8:    o = '{32'sd60713,     TERM_EST1, 2'd0};
			5'd9:    o = '{32'sd13,        TERM_EST2, 2'd0};
			5'd10:   o = '{32'sd0,         TERM_EST3, 2'd0};
			5'd11:   o = '{32'sd0,         TERM_KIX,  2'd0};
			5'd12:   o = '{32'sd4823,      TERM_POS,  2'd0};
			5'd13:   o = '{-32'sd159305,   TERM_EST1, 2'd1};
			5'd14:   o = '{32'sd65464,     TERM_EST2, 2'd1};
			5'd15:   o = '{32'sd13,        TERM_EST3, 2'd1};
			5'd16:   o = '{32'sd1824,      TERM_KIX,  2'd1};
			5'd17:   o = '{32'sd155058,    TERM_POS,  2'd1};
			5'd18:   o = '{-32'sd24644262, TERM_EST1, 2'd2};
			5'd19:   o = '{-32'sd737418,   TERM_EST2, 2'd2};
			5'd20:   o = '{32'sd60319,     TERM_EST3, 2'd2};
			5'd21:   o = '{32'sd17946712,  TERM_KIX,  2'd2};
			5'd22:   o = '{-32'sd17148687, TERM_POS,  2'd2};
			default: o = '{32'sd0,         TERM_EST1, 2'd0};
		endcase
		return o;
	endfunction

endpackage
`default_nettype wire

### src/osfi_mul.sv
// Shared signed multiplier with registered product
`default_nettype none
module osfi_mul (
	input  wire logic                                  clk,
	input  wire logic signed [osfi_pkg::MUL_W-1:0]     a,
	input  wire logic signed [osfi_pkg::MUL_W-1:0]     b,
	output logic signed [osfi_pkg::PROD_W-1:0]         prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule
`default_nettype wire

### src/observer_state_feedback_integrator.sv
// Observer state feedback controller with integral action, top level
// Usage: one sample enters on the in channel (valid/ready) carrying the
// setpoint code and encoder count; one result beat leaves on the out
// channel with position code, drive code and clip flag.
// One shared 33x33 multiplier is stepped through 23 products by a
// step counter, one product per cycle. The block takes no new sample
// until the current one is committed. Gains, limits and offsets sit
// in registers written through the cfg port (write enable, index,
// data); the user must write them only while the block is idle, as
// the block itself does not enforce it.
// Reset clears observer states, integrator, previous position and loads
// the default register values; no output is pending after reset.
// A stalled receiver holds the output beat; a finished computation then
// waits at its last step and commits once the output register frees.
// Config writes to an index beyond the register list are dropped.
`default_nettype none
`include "observer_state_feedback_integrator_defines.svh"
module observer_state_feedback_integrator (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire osfi_pkg::in_item_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output osfi_pkg::out_item_t       out_data,
	input  wire logic                 cfg_wen,
	input  wire logic [2:0]           cfg_idx,
	input  wire logic [31:0]          cfg_wdata
);

	logic signed [31:0] gain_state1_q, gain_state2_q, gain_state3_q, gain_integral_q;
	logic signed [31:0] zero_offset_q;
	logic [30:0]        drive_limit_q, dac_gain_q;

	logic signed [31:0] est1_q, est2_q, est3_q, err_int_q, prev_pos_q;
	logic signed [31:0] xs0_q, xs1_q;

	osfi_pkg::state_t state_q, state_d;
	logic [4:0]       step_q, tag_q;
	logic             tag_v_q;
	logic             commit;
	logic             in_fire;

	logic [11:0]        code_q;
	logic [14:0]        count_q;
	logic signed [31:0] kix_q, rin_q, pos_q, v_q;
	logic               clip_q;
	logic [11:0]        pcode_q, dcode_q;
	logic signed [63:0] acc_q;

	logic signed [osfi_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic signed [osfi_pkg::PROD_W-1:0] prod_q;
	logic signed [63:0]                 term, acc_sum;
	osfi_pkg::obs_op_t                  op_issue, op_tag;
	logic [26:0]                        count4095;

	logic signed [63:0] drv64;
	logic signed [31:0] drv_s, drv_c;
	logic signed [33:0] drv34, lim34;
	logic               clip_d;
	logic signed [33:0] dq;
	logic [18:0]        pc_raw;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_state1_q   <= osfi_pkg::RST_GAIN_STATE1;
			gain_state2_q   <= osfi_pkg::RST_GAIN_STATE2;
			gain_state3_q   <= osfi_pkg::RST_GAIN_STATE3;
			gain_integral_q <= osfi_pkg::RST_GAIN_INTEGRAL;
			drive_limit_q   <= osfi_pkg::RST_DRIVE_LIMIT;
			zero_offset_q   <= osfi_pkg::RST_ZERO_OFFSET;
			dac_gain_q      <= osfi_pkg::RST_DAC_GAIN;
		end else if (cfg_wen) begin
			unique case (osfi_pkg::reg_idx_t'(cfg_idx))
				osfi_pkg::REG_GAIN_STATE1:   gain_state1_q   <= cfg_wdata;
				osfi_pkg::REG_GAIN_STATE2:   gain_state2_q   <= cfg_wdata;
				osfi_pkg::REG_GAIN_STATE3:   gain_state3_q   <= cfg_wdata;
				osfi_pkg::REG_GAIN_INTEGRAL: gain_integral_q <= cfg_wdata;
				osfi_pkg::REG_DRIVE_LIMIT:   drive_limit_q   <= cfg_wdata[30:0];
				osfi_pkg::REG_ZERO_OFFSET:   zero_offset_q   <= cfg_wdata;
				osfi_pkg::REG_DAC_GAIN:      dac_gain_q      <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			osfi_pkg::ST_IDLE: if (in_fire) state_d = osfi_pkg::ST_RUN;
			osfi_pkg::ST_RUN:  if (commit) state_d = osfi_pkg::ST_IDLE;
			default:           state_d = osfi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == osfi_pkg::ST_IDLE);
		in_fire  = in_valid && in_ready;
		commit   = (state_q == osfi_pkg::ST_RUN) && (step_q == osfi_pkg::STEP_LAST)
			&& (!out_valid || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= osfi_pkg::ST_IDLE;
			step_q  <= '0;
			tag_v_q <= 1'b0;
			tag_q   <= '0;
		end else begin
			state_q <= state_d;
			tag_v_q <= (state_q == osfi_pkg::ST_RUN);
			tag_q   <= step_q;
			if (in_fire) begin
				step_q <= '0;
			end else if (state_q == osfi_pkg::ST_RUN && step_q != osfi_pkg::STEP_LAST) begin
				step_q <= step_q + 5'd1;
			end
		end
	end

	// capture sample; negative counts clamp to zero
	always_ff @(posedge clk) begin
		if (in_fire) begin
			code_q  <= in_data.setpoint_code;
			count_q <= in_data.encoder_count[15] ? 15'd0 : in_data.encoder_count[14:0];
		end
	end

	// operand select
	always_comb begin
		count4095 = {count_q, 12'd0} - {12'd0, count_q};
		op_issue  = osfi_pkg::obs_op(step_q);
		mul_a     = '0;
		mul_b     = '0;
		case (step_q)
			osfi_pkg::STEP_KIX: begin
				mul_a = {gain_integral_q[31], gain_integral_q};
				mul_b = {err_int_q[31], err_int_q};
			end
			osfi_pkg::STEP_FB1: begin
				mul_a = {gain_state1_q[31], gain_state1_q};
				mul_b = {est1_q[31], est1_q};
			end
			osfi_pkg::STEP_FB2: begin
				mul_a = {gain_state2_q[31], gain_state2_q};
				mul_b = {est2_q[31], est2_q};
			end
			osfi_pkg::STEP_FB3: begin
				mul_a = {gain_state3_q[31], gain_state3_q};
				mul_b = {est3_q[31], est3_q};
			end
			osfi_pkg::STEP_RIN: begin
				mul_a = {5'd0, code_q, 16'd0};
				mul_b = osfi_pkg::RECIP_4095;
			end
			osfi_pkg::STEP_POS: begin
				mul_a = {2'd0, count_q, 16'd0};
				mul_b = osfi_pkg::RECIP_700_POS;
			end
			osfi_pkg::STEP_PCODE: begin
				mul_a = {6'd0, count4095};
				mul_b = osfi_pkg::RECIP_700_CODE;
			end
			osfi_pkg::STEP_DCODE: begin
				mul_a = {v_q[31], v_q};
				mul_b = {2'd0, dac_gain_q};
			end
			default: begin
				mul_a = {op_issue.coef[31], op_issue.coef};
				case (op_issue.term)
					osfi_pkg::TERM_EST1: mul_b = {est1_q[31], est1_q};
					osfi_pkg::TERM_EST2: mul_b = {est2_q[31], est2_q};
					osfi_pkg::TERM_EST3: mul_b = {est3_q[31], est3_q};
					osfi_pkg::TERM_KIX:  mul_b = {kix_q[31], kix_q};
					default:             mul_b = {prev_pos_q[31], prev_pos_q};
				endcase
			end
		endcase
	end

	osfi_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// product consumption
	always_comb begin
		term    = {{14{prod_q[65]}}, prod_q[65:16]};
		acc_sum = acc_q + term;
		op_tag  = osfi_pkg::obs_op(tag_q);

		drv64 = {{32{kix_q[31]}}, kix_q} - acc_q;
		drv_s = osfi_pkg::sat32(drv64);
		drv34 = {{2{drv_s[31]}}, drv_s};
		lim34 = {3'd0, drive_limit_q};
		clip_d = (drv34 >= lim34) || (-drv34 >= lim34);
		if (clip_d) begin
			drv_c = drv_s[31] ? -$signed({1'b0, drive_limit_q}) : $signed({1'b0, drive_limit_q});
		end else begin
			drv_c = drv_s;
		end

		dq     = prod_q[65:32] + 34'sd2048;
		pc_raw = prod_q[55:37];
	end

	always_ff @(posedge clk) begin
		if (tag_v_q) begin
			case (tag_q)
				osfi_pkg::STEP_KIX: kix_q <= osfi_pkg::sat32(term);
				osfi_pkg::STEP_FB1: acc_q <= term;
				osfi_pkg::STEP_FB2: acc_q <= acc_sum;
				osfi_pkg::STEP_FB3: acc_q <= acc_sum;
				osfi_pkg::STEP_RIN: begin
					rin_q  <= $signed({15'd0, prod_q[56:40]}) - osfi_pkg::SETPOINT_OFFSET;
					clip_q <= clip_d;
					v_q    <= osfi_pkg::sat32({{32{drv_c[31]}}, drv_c}
						+ {{32{zero_offset_q[31]}}, zero_offset_q});
				end
				osfi_pkg::STEP_POS: pos_q <= {10'd0, prod_q[62:41]};
				osfi_pkg::STEP_PCODE: pcode_q <= (pc_raw > 19'd4095) ? 12'd4095 : pc_raw[11:0];
				osfi_pkg::STEP_DCODE: begin
					if (dq < 34'sd0) begin
						dcode_q <= 12'd0;
					end else if (dq > 34'sd4095) begin
						dcode_q <= 12'd4095;
					end else begin
						dcode_q <= dq[11:0];
					end
				end
				default: begin
					if (tag_q >= osfi_pkg::STEP_OBS0 && tag_q <= osfi_pkg::STEP_OBS14) begin
						if (op_tag.term == osfi_pkg::TERM_EST1) begin
							acc_q <= term;
						end else begin
							acc_q <= acc_sum;
						end
						if (op_tag.term == osfi_pkg::TERM_POS && op_tag.row == 2'd0) begin
							xs0_q <= osfi_pkg::sat32(acc_sum);
						end
						if (op_tag.term == osfi_pkg::TERM_POS && op_tag.row == 2'd1) begin
							xs1_q <= osfi_pkg::sat32(acc_sum);
						end
					end
				end
			endcase
		end
	end

	// commit state and result; row 2 finishes in the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est1_q     <= '0;
			est2_q     <= '0;
			est3_q     <= '0;
			err_int_q  <= '0;
			prev_pos_q <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (commit) begin
				est1_q     <= xs0_q;
				est2_q     <= xs1_q;
				est3_q     <= osfi_pkg::sat32(acc_q);
				err_int_q  <= osfi_pkg::sat32({{32{err_int_q[31]}}, err_int_q}
					+ {{32{rin_q[31]}}, rin_q} - {{32{pos_q[31]}}, pos_q});
				prev_pos_q <= pos_q;
				out_valid  <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data.position_code <= pcode_q;
			out_data.drive_code    <= dcode_q;
			out_data.drive_clipped <= clip_q;
		end
	end

	`OSFI_ASSERT_NEXT(a_start, clk, arst_n, in_fire, state_q == osfi_pkg::ST_RUN && step_q == 5'd0)
	`OSFI_ASSERT_IMPL(a_step_range, clk, arst_n, state_q == osfi_pkg::ST_RUN, step_q <= osfi_pkg::STEP_LAST)
	`OSFI_ASSERT_NEXT(a_commit_out, clk, arst_n, commit, out_valid && state_q == osfi_pkg::ST_IDLE)
	`OSFI_ASSERT_IMPL(a_busy_no_ready, clk, arst_n, state_q == osfi_pkg::ST_RUN, !in_ready)

endmodule
`default_nettype wire

### sim/tb_observer_state_feedback_integrator.sv
// Testbench for the observer state feedback integrator: random and directed samples checked against a predictor
`default_nettype none
module tb_observer_state_feedback_integrator;

	localparam logic [2:0] IDX_UNUSED = 3'd7;
	localparam int         SETTLE_CYCLES = 40;
	localparam int         PHASE_ITEMS = 220;
	localparam longint     QMAX = 64'sd2147483647;
	localparam longint     QMIN = -64'sd2147483648;
	// A row-major, B, L, setpoint offset, in millionths
	localparam longint     COEF_MICRO [16] = '{
		926400, 200, 0,
		-2430800, 998900, 200,
		-376041600, -11252100, 920400,
		0, 27830, 273845100,
		73600, 2366000, -261668200,
		30000};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	osfi_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	osfi_pkg::out_item_t out_data;
	logic                cfg_wen = 1'b0;
	logic [2:0]          cfg_idx = '0;
	logic [31:0]         cfg_wdata = '0;

	osfi_pkg::in_item_t  sample_q [$];
	osfi_pkg::out_item_t result_q [$];
	int        err_cnt = 0;
	int        beats_in = 0;
	int        beats_out = 0;
	int        clip_cnt = 0;
	int        send_gap = 0;
	int        recv_gap = 0;
	bit        busy_sides = 1'b1;

	longint k1, k2, k3, ki, lim, zoff, dgain;
	longint est1, est2, est3, integ, last_pos;

	observer_state_feedback_integrator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	function automatic longint clamp32(input longint v);
		return (v > QMAX) ? QMAX : ((v < QMIN) ? QMIN : v);
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic longint qcoef(input int i);
		longint n;
		longint q;
		n = COEF_MICRO[i] * 65536;
		if (n >= 0) q = (n + 500000) / 1000000;
		else q = -((-n + 500000) / 1000000);
		return clamp32(q);
	endfunction

	task automatic shadow_reset();
		k1 = osfi_pkg::RST_GAIN_STATE1; k2 = osfi_pkg::RST_GAIN_STATE2;
		k3 = osfi_pkg::RST_GAIN_STATE3; ki = osfi_pkg::RST_GAIN_INTEGRAL;
		lim = osfi_pkg::RST_DRIVE_LIMIT; zoff = osfi_pkg::RST_ZERO_OFFSET;
		dgain = osfi_pkg::RST_DAC_GAIN;
		est1 = 0; est2 = 0; est3 = 0; integ = 0; last_pos = 0;
	endtask

	task automatic predict_sample(input osfi_pkg::in_item_t s);
		longint cnt, rin, pos, pcode, kix, fb, drv, v, dcode;
		longint prv [3];
		longint nxt [3];
		bit clip;
		osfi_pkg::out_item_t r;
		cnt = longint'(s.encoder_count);
		if (cnt < 0) cnt = 0;
		rin = clamp32((longint'(s.setpoint_code) * 65536) / 4095 - qcoef(15));
		pos = clamp32((cnt * 65536) / 700);
		pcode = (cnt * 4095) / 700;
		if (pcode > 4095) pcode = 4095;
		kix = clamp32(qmul(ki, integ));
		fb = qmul(k1, est1) + qmul(k2, est2) + qmul(k3, est3);
		drv = clamp32(kix - fb);
		clip = (drv >= lim) || (-drv >= lim);
		if (clip) drv = (drv < 0) ? -lim : lim;
		v = clamp32(drv + zoff);
		dcode = (qmul(v, dgain) >>> 16) + 2048;
		if (dcode < 0) dcode = 0;
		if (dcode > 4095) dcode = 4095;
		prv[0] = est1; prv[1] = est2; prv[2] = est3;
		for (int row = 0; row < 3; row++) begin
			nxt[row] = clamp32(qmul(qcoef(row * 3), prv[0]) + qmul(qcoef(row * 3 + 1), prv[1])
				+ qmul(qcoef(row * 3 + 2), prv[2]) + qmul(qcoef(9 + row), kix)
				+ qmul(qcoef(12 + row), last_pos));
		end
		est1 = nxt[0]; est2 = nxt[1]; est3 = nxt[2];
		integ = clamp32(integ + rin - pos);
		last_pos = pos;
		r.position_code = pcode[11:0];
		r.drive_code = dcode[11:0];
		r.drive_clipped = clip;
		result_q.push_back(r);
	endtask

	// driver
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predict_sample(in_data);
			beats_in++;
		end
		if (in_valid && !in_ready) begin
			in_valid <= 1'b1;
		end else if (send_gap > 0) begin
			send_gap <= send_gap - 1;
			in_valid <= 1'b0;
		end else if (sample_q.size() > 0) begin
			in_valid <= 1'b1;
			in_data <= sample_q.pop_front();
			send_gap <= busy_sides ? $urandom_range(0, 3) : 0;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			beats_out++;
			if (result_q.size() == 0) begin
				$display("%0t: unexpected beat, actual %p", $time, out_data);
				err_cnt++;
			end else begin
				osfi_pkg::out_item_t e;
				e = result_q.pop_front();
				if (e.drive_clipped) clip_cnt++;
				if (e.position_code !== out_data.position_code) begin
					$display("%0t: position_code expected %0d actual %0d", $time,
						e.position_code, out_data.position_code);
					err_cnt++;
				end
				if (e.drive_code !== out_data.drive_code) begin
					$display("%0t: drive_code expected %0d actual %0d", $time,
						e.drive_code, out_data.drive_code);
					err_cnt++;
				end
				if (e.drive_clipped !== out_data.drive_clipped) begin
					$display("%0t: drive_clipped expected %0b actual %0b", $time,
						e.drive_clipped, out_data.drive_clipped);
					err_cnt++;
				end
			end
		end
		if (out_valid && out_ready) begin
			recv_gap = busy_sides ? $urandom_range(0, 3) : 0;
		end
		if (recv_gap > 0) begin
			recv_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			osfi_pkg::REG_GAIN_STATE1:   k1 = longint'($signed(val));
			osfi_pkg::REG_GAIN_STATE2:   k2 = longint'($signed(val));
			osfi_pkg::REG_GAIN_STATE3:   k3 = longint'($signed(val));
			osfi_pkg::REG_GAIN_INTEGRAL: ki = longint'($signed(val));
			osfi_pkg::REG_DRIVE_LIMIT:   lim = longint'(val[30:0]);
			osfi_pkg::REG_ZERO_OFFSET:   zoff = longint'($signed(val));
			osfi_pkg::REG_DAC_GAIN:      dgain = longint'(val[30:0]);
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic drain();
		while (sample_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_sample(input int sp, input int cnt);
		osfi_pkg::in_item_t s;
		s.setpoint_code = sp[11:0];
		s.encoder_count = cnt[15:0];
		sample_q.push_back(s);
	endtask

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 7) push_sample($urandom_range(0, 4095), $urandom_range(0, 800));
			else push_sample($urandom_range(0, 4095), $urandom_range(0, 65535));
		end
	endtask

	task automatic random_cfg();
		write_reg(osfi_pkg::REG_GAIN_STATE1, $urandom_range(0, 300000) - 150000);
		write_reg(osfi_pkg::REG_GAIN_STATE2, $urandom_range(0, 4000) - 2000);
		write_reg(osfi_pkg::REG_GAIN_STATE3, $urandom_range(0, 200) - 100);
		write_reg(osfi_pkg::REG_GAIN_INTEGRAL, $urandom_range(0, 4000) - 2000);
		write_reg(osfi_pkg::REG_DRIVE_LIMIT, $urandom_range(0, 2000000));
		write_reg(osfi_pkg::REG_ZERO_OFFSET, $urandom_range(0, 200000) - 100000);
		write_reg(osfi_pkg::REG_DAC_GAIN, $urandom_range(0, 20000000));
		end_writes();
	endtask

	initial begin
		shadow_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: field extremes, negative and beyond-full-scale counts
		push_sample(0, 0); push_sample(4095, 0); push_sample(0, 32767);
		push_sample(4095, 32767); push_sample(2048, -32768); push_sample(2048, -1);
		push_sample(123, 700); push_sample(3000, 699); push_sample(3000, 701);
		push_sample(4095, 1); push_sample(1, 350); push_sample(4095, 0);
		push_sample(4095, 0); push_sample(4095, 0); push_sample(0, 32767);
		push_sample(2730, 21845); push_sample(1365, 10922);
		drain();

		// zero limit: drive always zero and clipped; unused index dropped
		write_reg(osfi_pkg::REG_DRIVE_LIMIT, 32'd0);
		write_reg(IDX_UNUSED, 32'hffffffff);
		end_writes();
		push_random(PHASE_ITEMS);
		drain();

		// gain and offset extremes with widest limit
		busy_sides = 1'b0;
		write_reg(osfi_pkg::REG_GAIN_STATE1, 32'h7fffffff);
		write_reg(osfi_pkg::REG_GAIN_STATE2, 32'h80000000);
		write_reg(osfi_pkg::REG_GAIN_STATE3, 32'h7fffffff);
		write_reg(osfi_pkg::REG_GAIN_INTEGRAL, 32'h80000000);
		write_reg(osfi_pkg::REG_DRIVE_LIMIT, 32'hffffffff);
		write_reg(osfi_pkg::REG_ZERO_OFFSET, 32'h80000000);
		write_reg(osfi_pkg::REG_DAC_GAIN, 32'h7fffffff);
		end_writes();
		push_random(PHASE_ITEMS / 2);
		drain();
		busy_sides = 1'b1;

		write_reg(osfi_pkg::REG_GAIN_STATE1, 32'h80000000);
		write_reg(osfi_pkg::REG_GAIN_STATE2, 32'h7fffffff);
		write_reg(osfi_pkg::REG_GAIN_STATE3, 32'h80000000);
		write_reg(osfi_pkg::REG_GAIN_INTEGRAL, 32'h7fffffff);
		write_reg(osfi_pkg::REG_DRIVE_LIMIT, 32'h7fffffff);
		write_reg(osfi_pkg::REG_ZERO_OFFSET, 32'h7fffffff);
		write_reg(osfi_pkg::REG_DAC_GAIN, 32'd0);
		end_writes();
		push_random(PHASE_ITEMS / 2);
		drain();

		for (int p = 0; p < 5; p++) begin
			if (p == 4) begin
				for (int r = 0; r <= 6; r++) write_reg(r[2:0], $urandom());
				end_writes();
			end else begin
				random_cfg();
			end
			push_random(PHASE_ITEMS);
			drain();
		end

		$display("Sent %0d samples and checked %0d result beats, %0d with the drive clipped,",
			beats_in, beats_out, clip_cnt);
		$display("over default, zero-limit, extreme and random register settings.");
		if (err_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#40000000;
		$display("Timeout with %0d results outstanding", result_q.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
